>>> hw/rtl/rmp_pkg.sv
// Shared types and constants of the region metadata parser.
// Used by every module of the block; depends on nothing.
package rmp_pkg;

   localparam int LENGTH_BITS_DEF = 48;
   localparam int IV_BYTES_DEF    = 16;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int OUT_W       = 48;
   localparam int CNT_W       = 56;
   localparam int FIELD_W     = 64;
   localparam int WIN_W       = 16;
   localparam int SEQ_BYTES   = 8;
   localparam int HDR_END     = 12;
   localparam int COUNT_BYTES = 8;
   localparam int RSP_DATA_W  = 112;
   localparam int CSR_INDEX_W = 2;

   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(50);

   localparam logic [CSR_INDEX_W-1:0] CSR_SEQ_LENGTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_SIZE = CSR_INDEX_W'(1);

   typedef enum logic [2:0] {
      OP_NONE,
      OP_SEQ_LEN,
      OP_WINDOW,
      OP_IV,
      OP_COUNT,
      OP_START,
      OP_LENGTH
   } op_type;

   typedef enum logic [1:0] {
      KIND_IV       = 2'd0,
      KIND_INTERVAL = 2'd1,
      KIND_STATUS   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_TRUNC_HDR    = 3'd1,
      ST_HDR_MISMATCH = 3'd2,
      ST_SHORT_PREFIX = 3'd3,
      ST_BAD_COUNT    = 3'd4,
      ST_BAD_INTERVAL = 3'd5
   } status_type;

   typedef struct packed {
      logic [OUT_W-1:0] seq_length;
      logic [WIN_W-1:0] window_size;
   } cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      op_type             op;
      logic [FIELD_W-1:0] value;
      logic               last;
      logic               short_hdr;
      logic               short_prefix;
      logic               count_bad;
   } cmd_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       iv_value;
      logic [OUT_W-1:0] interval_start;
      logic [OUT_W-1:0] interval_length;
      status_type       status;
      logic             final_flag;
   } rsp_type;

endpackage

>>> hw/rtl/region_metadata_parser.sv
// Region metadata parser: one record byte is taken per cycle. Bytes pass a
// front end that tracks position and assembles 64-bit fields, then a queue of
// QUEUE_DEPTH commands, then a back end that checks and emits results. Only
// IV bytes, field-completing bytes and final bytes enter the queue. Each
// command is registered in the queue and each result in the output register;
// a final byte that also completes an IV byte or interval holds the back end
// for an extra result (its own result, then the status). The queue absorbs
// that hold, so while the result side is ready the input takes one byte per
// cycle with no gap; the input stalls only when result back-pressure fills
// the queue. Uses rmp_pkg, rmp_front, rmp_queue, rmp_back.
module region_metadata_parser #(
   parameter int LENGTH_BITS = rmp_pkg::LENGTH_BITS_DEF,
   parameter int IV_BYTES    = rmp_pkg::IV_BYTES_DEF,
   parameter int QUEUE_DEPTH = rmp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // data_byte
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // iv_value, interval_start, interval_length, status, zero fill
   output logic [rmp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [1:0]                         rsp_tuser,   // kind
   output logic                               rsp_tlast,   // final_flag
   input  logic                               csr_we,
   input  logic [rmp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rmp_pkg::OUT_W-1:0]          csr_wdata
);

   localparam int USED_W = 8 + 2 * rmp_pkg::OUT_W + 3;

   rmp_pkg::cfg_type cfg_ff, cfg_in;
   rmp_pkg::cmd_type front_cmd, queue_cmd;
   rmp_pkg::rsp_type rsp;
   logic             front_push, queue_full, queue_valid, queue_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            rmp_pkg::CSR_SEQ_LENGTH:  cfg_in.seq_length = csr_wdata;
            rmp_pkg::CSR_WINDOW_SIZE: cfg_in.window_size = csr_wdata[rmp_pkg::WIN_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seq_length  <= '0;
         cfg_ff.window_size <= rmp_pkg::WINDOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rmp_front #(
      .LENGTH_BITS (LENGTH_BITS),
      .IV_BYTES    (IV_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_data    (req_tdata),
      .in_last    (req_tlast),
      .queue_full (queue_full),
      .push       (front_push),
      .cmd        (front_cmd)
   );

   rmp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .wr_data  (front_cmd),
      .full     (queue_full),
      .pop      (queue_pop),
      .rd_valid (queue_valid),
      .rd_data  (queue_cmd)
   );

   rmp_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (queue_valid),
      .q_cmd     (queue_cmd),
      .q_pop     (queue_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp)
   );

   assign rsp_tdata = {{(rmp_pkg::RSP_DATA_W - USED_W){1'b0}}, rsp.status,
                       rsp.interval_length, rsp.interval_start, rsp.iv_value};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.final_flag;

endmodule

>>> hw/rtl/rmp_front.sv
// Front end: takes record bytes, tracks position, assembles big-endian fields
// and classifies each byte into a command for the back end. Uses rmp_pkg.
module rmp_front #(
   parameter int LENGTH_BITS = rmp_pkg::LENGTH_BITS_DEF,
   parameter int IV_BYTES    = rmp_pkg::IV_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [7:0]       in_data,
   input  logic             in_last,
   input  logic             queue_full,
   output logic             push,
   output rmp_pkg::cmd_type cmd
);

   localparam int IV_END     = rmp_pkg::HDR_END + IV_BYTES;
   localparam int PREFIX_END = IV_END + rmp_pkg::COUNT_BYTES;
   localparam int CNT_W      = rmp_pkg::CNT_W;
   localparam int FIELD_W    = rmp_pkg::FIELD_W;

   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [CNT_W-1:0]       body_ff, body_in, body_next;
   logic [FIELD_W-1:0]     field_ff, field_in, field_shl;
   logic [LENGTH_BITS-1:0] decl_ff, decl_in, decl_next;
   logic                   take, cnt_sat, in_pairs;
   rmp_pkg::op_type        op;

   assign in_ready  = !queue_full;
   assign take      = in_valid && in_ready;
   assign field_shl = {field_ff[FIELD_W-9:0], in_data};
   assign cnt_sat   = (cnt_ff == '1);
   assign in_pairs  = (cnt_ff >= CNT_W'(PREFIX_END));

   always_comb begin
      priority if (cnt_ff < CNT_W'(rmp_pkg::SEQ_BYTES)) begin
         op = (cnt_ff == CNT_W'(rmp_pkg::SEQ_BYTES - 1)) ? rmp_pkg::OP_SEQ_LEN : rmp_pkg::OP_NONE;
      end else if (cnt_ff < CNT_W'(rmp_pkg::HDR_END)) begin
         op = (cnt_ff == CNT_W'(rmp_pkg::HDR_END - 1)) ? rmp_pkg::OP_WINDOW : rmp_pkg::OP_NONE;
      end else if (cnt_ff < CNT_W'(IV_END)) begin
         op = rmp_pkg::OP_IV;
      end else if (!in_pairs) begin
         op = (cnt_ff == CNT_W'(PREFIX_END - 1)) ? rmp_pkg::OP_COUNT : rmp_pkg::OP_NONE;
      end else if (body_ff[3:0] == 4'd7) begin
         op = rmp_pkg::OP_START;
      end else if (body_ff[3:0] == 4'd15) begin
         op = rmp_pkg::OP_LENGTH;
      end else begin
         op = rmp_pkg::OP_NONE;
      end
   end

   always_comb begin
      body_next = (in_pairs && !cnt_sat) ? body_ff + CNT_W'(1) : body_ff;
      decl_next = (op == rmp_pkg::OP_COUNT) ? field_shl[LENGTH_BITS-1:0] : decl_ff;

      cmd.op           = op;
      cmd.value        = (op == rmp_pkg::OP_IV) ? FIELD_W'(in_data) : field_shl;
      cmd.last         = in_last;
      cmd.short_hdr    = (cnt_ff < CNT_W'(rmp_pkg::HDR_END - 1));
      cmd.short_prefix = (cnt_ff < CNT_W'(PREFIX_END - 1));
      cmd.count_bad    = (body_next[3:0] != 4'd0) ||
                         (FIELD_W'(body_next[CNT_W-1:4]) != FIELD_W'(decl_next));

      push = take && ((op != rmp_pkg::OP_NONE) || in_last);

      cnt_in   = cnt_ff;
      body_in  = body_ff;
      field_in = field_ff;
      decl_in  = decl_ff;
      if (take) begin
         if (in_last) begin
            cnt_in   = '0;
            body_in  = '0;
            field_in = '0;
            decl_in  = '0;
         end else begin
            cnt_in  = cnt_sat ? cnt_ff : cnt_ff + CNT_W'(1);
            body_in = body_next;
            decl_in = decl_next;
            unique case (op)
               rmp_pkg::OP_NONE: field_in = field_shl;
               rmp_pkg::OP_IV:   field_in = field_ff;
               default:          field_in = '0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         body_ff  <= '0;
         field_ff <= '0;
         decl_ff  <= '0;
      end else begin
         cnt_ff   <= cnt_in;
         body_ff  <= body_in;
         field_ff <= field_in;
         decl_ff  <= decl_in;
      end
   end

endmodule

>>> hw/rtl/rmp_queue.sv
// Short command queue between front and back end.
// Uses rmp_pkg for the command type.
module rmp_queue #(
   parameter int DEPTH = rmp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rmp_pkg::cmd_type wr_data,
   output logic             full,
   input  logic             pop,
   output logic             rd_valid,
   output rmp_pkg::cmd_type rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rmp_pkg::cmd_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hw/rtl/rmp_back.sv
// Back end: runs the header, count and interval checks on classified commands,
// keeps the lowest fault and drives the result register. Uses rmp_pkg.
module rmp_back #(
   parameter int LENGTH_BITS = rmp_pkg::LENGTH_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  rmp_pkg::cfg_type cfg,
   input  logic             q_valid,
   input  rmp_pkg::cmd_type q_cmd,
   output logic             q_pop,
   output logic             out_valid,
   input  logic             out_ready,
   output rmp_pkg::rsp_type out_rsp
);

   localparam int FIELD_W = rmp_pkg::FIELD_W;
   localparam int OUT_W   = rmp_pkg::OUT_W;

   rmp_pkg::status_type    fault_ff, fault_in, fault_next, code, status;
   logic [LENGTH_BITS-1:0] prev_end_ff, prev_end_in;
   logic [LENGTH_BITS-1:0] start_ff, start_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   pend_valid_ff, pend_valid_in;
   rmp_pkg::rsp_type       out_ff, out_in, pend_ff, pend_in, first_rsp, status_rsp;
   logic [FIELD_W-1:0]     v, exp64, st64, sum64;
   logic                   hit, first_valid, out_free;

   assign v         = q_cmd.value;
   assign exp64     = FIELD_W'(cfg.seq_length);
   assign st64      = FIELD_W'(start_ff);
   assign sum64     = st64 + v;
   assign out_free  = !out_valid_ff || out_ready;
   assign out_valid = out_valid_ff;
   assign out_rsp   = out_ff;

   always_comb begin
      hit  = 1'b0;
      code = rmp_pkg::ST_OK;
      unique case (q_cmd.op)
         rmp_pkg::OP_SEQ_LEN: begin
            hit  = (v != exp64);
            code = rmp_pkg::ST_HDR_MISMATCH;
         end
         rmp_pkg::OP_WINDOW: begin
            hit  = (v != FIELD_W'(cfg.window_size));
            code = rmp_pkg::ST_HDR_MISMATCH;
         end
         rmp_pkg::OP_COUNT: begin
            hit  = (v > exp64);
            code = rmp_pkg::ST_BAD_COUNT;
         end
         rmp_pkg::OP_START: begin
            hit  = (v > exp64) || (v < FIELD_W'(prev_end_ff));
            code = rmp_pkg::ST_BAD_INTERVAL;
         end
         rmp_pkg::OP_LENGTH: begin
            hit  = (v == '0) || (st64 > exp64) || (v > exp64 - st64);
            code = rmp_pkg::ST_BAD_INTERVAL;
         end
         default: begin
            hit  = 1'b0;
            code = rmp_pkg::ST_OK;
         end
      endcase

      fault_next = (hit && ((fault_ff == rmp_pkg::ST_OK) || (code < fault_ff))) ? code : fault_ff;

      // faults present here are ok, header mismatch, bad count or bad interval
      priority if (q_cmd.short_hdr) begin
         status = rmp_pkg::ST_TRUNC_HDR;
      end else if (fault_next == rmp_pkg::ST_HDR_MISMATCH) begin
         status = rmp_pkg::ST_HDR_MISMATCH;
      end else if (q_cmd.short_prefix) begin
         status = rmp_pkg::ST_SHORT_PREFIX;
      end else if (q_cmd.count_bad) begin
         status = rmp_pkg::ST_BAD_COUNT;
      end else begin
         status = fault_next;
      end
   end

   always_comb begin
      first_valid = (q_cmd.op == rmp_pkg::OP_IV) || (q_cmd.op == rmp_pkg::OP_LENGTH);

      first_rsp                 = '0;
      first_rsp.kind            = (q_cmd.op == rmp_pkg::OP_IV) ? rmp_pkg::KIND_IV
                                                               : rmp_pkg::KIND_INTERVAL;
      first_rsp.status          = rmp_pkg::ST_OK;
      if (q_cmd.op == rmp_pkg::OP_IV) begin
         first_rsp.iv_value = v[7:0];
      end else begin
         first_rsp.interval_start  = OUT_W'(st64);
         first_rsp.interval_length = v[OUT_W-1:0];
      end

      status_rsp            = '0;
      status_rsp.kind       = rmp_pkg::KIND_STATUS;
      status_rsp.status     = status;
      status_rsp.final_flag = 1'b1;

      q_pop = q_valid && !pend_valid_ff &&
              (out_free || (!first_valid && !q_cmd.last));
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !out_ready;
      out_in        = out_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (pend_valid_ff && out_free) begin
         out_valid_in  = 1'b1;
         out_in        = pend_ff;
         pend_valid_in = 1'b0;
      end else if (q_pop && (first_valid || q_cmd.last)) begin
         out_valid_in  = 1'b1;
         out_in        = first_valid ? first_rsp : status_rsp;
         pend_valid_in = first_valid && q_cmd.last;
         pend_in       = status_rsp;
      end

      fault_in    = fault_ff;
      prev_end_in = prev_end_ff;
      start_in    = start_ff;
      if (q_pop) begin
         fault_in = fault_next;
         if (q_cmd.op == rmp_pkg::OP_START) begin
            start_in = v[LENGTH_BITS-1:0];
         end
         if (q_cmd.op == rmp_pkg::OP_LENGTH) begin
            prev_end_in = sum64[LENGTH_BITS-1:0];
         end
         if (q_cmd.last) begin
            fault_in    = rmp_pkg::ST_OK;
            prev_end_in = '0;
            start_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         fault_ff      <= rmp_pkg::ST_OK;
         prev_end_ff   <= '0;
         start_ff      <= '0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
         fault_ff      <= fault_in;
         prev_end_ff   <= prev_end_in;
         start_ff      <= start_in;
      end
   end

endmodule

>>> hw/rtl/rmp_checker.sv
// Port-level checks for region_metadata_parser, attached by bind.
// Uses rmp_pkg for kind and status codes.
module rmp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rmp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [1:0]                      rsp_tuser,
   input logic                            rsp_tlast
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_final_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == rmp_pkg::KIND_STATUS)) &&
                     (!rsp_tlast || (rsp_tdata[103:0] == '0 && rsp_tdata[106:104] <= 3'd5)))
      else $error("bad end-of-record result");

   a_data_zero_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[111:104] == '0 &&
         (rsp_tuser == rmp_pkg::KIND_IV || rsp_tuser == rmp_pkg::KIND_INTERVAL) &&
         (rsp_tuser != rmp_pkg::KIND_IV || rsp_tdata[103:8] == '0) &&
         (rsp_tuser != rmp_pkg::KIND_INTERVAL || rsp_tdata[7:0] == '0))
      else $error("stray bits in data result");

endmodule

bind region_metadata_parser rmp_checker u_rmp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

>>> verif/rmp_checker.sv
// Scoreboard for region_metadata_parser: tracks record parsing on each accepted
// request item, predicts the result items and compares them in order.
// Depends on rmp_pkg.
module rmp_scoreboard
   import rmp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [7:0]             req_tdata,   // data_byte
   input  logic                   req_tlast,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // iv_value, interval_start, interval_length, status, zero fill
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [1:0]             rsp_tuser,   // kind
   input  logic                   rsp_tlast,   // final_flag
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [OUT_W-1:0]       csr_wdata,
   output int                     fail_count,
   output int                     pending
);

   localparam int IV_END     = HDR_END + IV_BYTES_DEF;
   localparam int PREFIX_END = IV_END + COUNT_BYTES;
   localparam int MAX_SHOWN  = 10;

   logic [OUT_W-1:0]   cfg_seq_len;
   logic [WIN_W-1:0]   cfg_window;
   logic [CNT_W-1:0]   byte_pos;
   logic [FIELD_W-1:0] field_acc;
   logic [OUT_W-1:0]   declared_pairs;
   logic [OUT_W-1:0]   prev_end;
   logic [OUT_W-1:0]   pair_start;
   status_type         first_fault;
   rsp_type            expected_rsp[$];

   function automatic void note_fault(status_type code);
      if (first_fault == ST_OK || code < first_fault)
         first_fault = code;
   endfunction

   function automatic void push_result(kind_type kind, logic [7:0] iv, logic [OUT_W-1:0] start,
                                       logic [OUT_W-1:0] len, status_type st);
      rsp_type r;
      r.kind            = kind;
      r.iv_value        = iv;
      r.interval_start  = start;
      r.interval_length = len;
      r.status          = st;
      r.final_flag      = (kind == KIND_STATUS);
      expected_rsp.insert(expected_rsp.size(), r);
   endfunction

   function automatic void clear_record();
      byte_pos       = '0;
      field_acc      = '0;
      declared_pairs = '0;
      prev_end       = '0;
      pair_start     = '0;
      first_fault    = ST_OK;
   endfunction

   function automatic void parse_byte(logic [7:0] b, logic fin);
      logic [3:0]         slot;
      logic [FIELD_W-1:0] body;
      status_type         st;
      slot = 4'(byte_pos - CNT_W'(PREFIX_END));
      if (byte_pos >= CNT_W'(HDR_END) && byte_pos < CNT_W'(IV_END)) begin
         push_result(KIND_IV, b, '0, '0, ST_OK);
      end else begin
         field_acc = {field_acc[FIELD_W-9:0], b};
         if (byte_pos == CNT_W'(SEQ_BYTES - 1)) begin
            if (field_acc != FIELD_W'(cfg_seq_len))
               note_fault(ST_HDR_MISMATCH);
            field_acc = '0;
         end else if (byte_pos == CNT_W'(HDR_END - 1)) begin
            if (field_acc != FIELD_W'(cfg_window))
               note_fault(ST_HDR_MISMATCH);
            field_acc = '0;
         end else if (byte_pos == CNT_W'(PREFIX_END - 1)) begin
            if (field_acc > FIELD_W'(cfg_seq_len))
               note_fault(ST_BAD_COUNT);
            declared_pairs = field_acc[OUT_W-1:0];
            field_acc = '0;
         end else if (byte_pos >= CNT_W'(PREFIX_END) && slot == 4'd7) begin
            if (field_acc > FIELD_W'(cfg_seq_len) || field_acc < FIELD_W'(prev_end))
               note_fault(ST_BAD_INTERVAL);
            pair_start = field_acc[OUT_W-1:0];
            field_acc = '0;
         end else if (byte_pos >= CNT_W'(PREFIX_END) && slot == 4'd15) begin
            if (field_acc == '0 || pair_start > cfg_seq_len ||
                field_acc > FIELD_W'(cfg_seq_len) - FIELD_W'(pair_start))
               note_fault(ST_BAD_INTERVAL);
            prev_end = pair_start + field_acc[OUT_W-1:0];
            push_result(KIND_INTERVAL, '0, pair_start, field_acc[OUT_W-1:0], ST_OK);
            field_acc = '0;
         end
      end
      if (byte_pos != '1)
         byte_pos = byte_pos + 1'b1;
      if (fin) begin
         if (byte_pos < CNT_W'(HDR_END)) begin
            st = ST_TRUNC_HDR;
         end else if (first_fault == ST_HDR_MISMATCH) begin
            st = ST_HDR_MISMATCH;
         end else if (byte_pos < CNT_W'(PREFIX_END)) begin
            st = ST_SHORT_PREFIX;
         end else begin
            body = FIELD_W'(byte_pos - CNT_W'(PREFIX_END));
            if (body[3:0] != 4'd0 || (body >> 4) != FIELD_W'(declared_pairs))
               note_fault(ST_BAD_COUNT);
            st = first_fault;
         end
         push_result(KIND_STATUS, '0, '0, '0, st);
         clear_record();
      end
   endfunction

   function automatic string rsp_text(rsp_type r);
      return $sformatf("kind=%0d iv=%h start=%h len=%h status=%0d final=%b", r.kind,
                       r.iv_value, r.interval_start, r.interval_length, r.status,
                       r.final_flag);
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         cfg_seq_len = '0;
         cfg_window  = WINDOW_RESET;
         clear_record();
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind            = kind_type'(rsp_tuser);
            got.iv_value        = rsp_tdata[7:0];
            got.interval_start  = rsp_tdata[8 +: OUT_W];
            got.interval_length = rsp_tdata[8 + OUT_W +: OUT_W];
            got.status          = status_type'(rsp_tdata[8 + 2 * OUT_W +: 3]);
            got.final_flag      = rsp_tlast;
            if (expected_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_SHOWN)
                  $display("result item with nothing expected: %s", rsp_text(got));
            end else begin
               want = expected_rsp.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= MAX_SHOWN)
                     $display("result mismatch\n  expected %s\n  actual   %s",
                              rsp_text(want), rsp_text(got));
               end
            end
         end
         if (req_tvalid && req_tready)
            parse_byte(req_tdata, req_tlast);
         if (csr_we) begin
            case (csr_index)
               CSR_SEQ_LENGTH:  cfg_seq_len = csr_wdata;
               CSR_WINDOW_SIZE: cfg_window  = csr_wdata[WIN_W-1:0];
               default: ;
            endcase
         end
      end
      pending = expected_rsp.size();
   end

endmodule

>>> verif/tb_top.sv
// Testbench top for region_metadata_parser: clock, reset, record stimulus,
// configuration phases, output back-pressure and the final verdict.
// Depends on rmp_pkg, region_metadata_parser and rmp_scoreboard.
module tb_top;
   import rmp_pkg::*;

   typedef enum int {
      REC_GOOD,
      REC_SEQ_BAD,
      REC_WIN_BAD,
      REC_TRUNC,
      REC_COUNT_BAD,
      REC_PAIR_BAD,
      REC_NOISE
   } flavor_type;

   localparam int PREFIX_END      = HDR_END + IV_BYTES_DEF + COUNT_BYTES;
   localparam int PHASES          = 6;
   localparam int DIRECTED_ITEMS  = 24;
   localparam int PHASE_ITEMS     = 190;
   localparam int HOLD_CYCLES     = 300;
   localparam int SETTLE_CYCLES   = 8;
   localparam int WATCHDOG_CYCLES = 3000;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [OUT_W-1:0]       csr_wdata  = '0;
   int                     fail_count;
   int                     pending;

   logic [OUT_W-1:0] cfg_len     = '0;
   logic [WIN_W-1:0] cfg_win     = WINDOW_RESET;
   logic [7:0]       rec_bytes[$];
   logic [63:0]      pair_start[$];
   logic [63:0]      pair_len[$];
   int               sent_items  = 0;
   int               idle_cycles = 0;
   logic             steady_send = 1'b0;
   logic             hold_rsp    = 1'b0;

   region_metadata_parser dut (.*);

   rmp_scoreboard scoreboard (.*);

   always #10 clock = ~clock;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void append_be(logic [63:0] v, int nbytes);
      for (int k = nbytes - 1; k >= 0; k--)
         rec_bytes.insert(rec_bytes.size(), v[8*k +: 8]);
   endfunction

   function automatic flavor_type pick_flavor();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return REC_GOOD;
      if (r < 53) return REC_SEQ_BAD;
      if (r < 60) return REC_WIN_BAD;
      if (r < 72) return REC_TRUNC;
      if (r < 82) return REC_COUNT_BAD;
      if (r < 94) return REC_PAIR_BAD;
      return REC_NOISE;
   endfunction

   // well-formed record for the current settings, then the flavor's damage; noise gives random bytes
   function automatic void build_record(flavor_type flavor);
      logic [63:0] seq_field;
      logic [31:0] win_field;
      logic [63:0] count_field;
      logic [63:0] cursor;
      logic [63:0] rem;
      logic [63:0] start;
      logic [63:0] len;
      int          npairs;
      int          idx;
      int          cut;
      rec_bytes.delete();
      pair_start.delete();
      pair_len.delete();
      if (flavor == REC_NOISE) begin
         repeat ($urandom_range(1, 60)) rec_bytes.insert(rec_bytes.size(), 8'($urandom));
         return;
      end
      seq_field = 64'(cfg_len);
      win_field = 32'(cfg_win);
      npairs = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 3);
      cursor = '0;
      for (int k = 0; k < npairs; k++) begin
         rem = 64'(cfg_len) - cursor;
         if (rem == 0)
            break;
         start = ($urandom_range(0, 3) == 0) ? cursor : cursor + rand64() % (rem / 2 + 1);
         rem = 64'(cfg_len) - start;
         len = ($urandom_range(0, 5) == 0) ? rem : 1 + rand64() % (rem / 2 + 1);
         pair_start.insert(pair_start.size(), start);
         pair_len.insert(pair_len.size(), len);
         cursor = start + len;
      end
      count_field = 64'(pair_start.size());
      case (flavor)
         REC_SEQ_BAD: seq_field ^= 64'(1) << $urandom_range(0, 63);
         REC_WIN_BAD: win_field ^= 32'(1) << $urandom_range(0, 31);
         REC_COUNT_BAD: begin
            case ($urandom_range(0, 3))
               0: count_field = count_field + 1;
               1: count_field = rand64();
               2: count_field = 64'(cfg_len) + 1;
               default: begin
                  if (pair_start.size() > 0) begin
                     pair_start.delete(pair_start.size() - 1);
                     pair_len.delete(pair_len.size() - 1);
                  end else begin
                     count_field = count_field + 1;
                  end
               end
            endcase
         end
         REC_PAIR_BAD: begin
            if (pair_start.size() == 0) begin
               pair_start.insert(pair_start.size(), rand64());
               pair_len.insert(pair_len.size(), rand64());
               count_field = 1;
            end
            idx = $urandom_range(0, pair_start.size() - 1);
            case ($urandom_range(0, 3))
               0: pair_len[idx] = '0;
               1: begin
                  if (idx > 0)
                     pair_start[idx] = pair_start[idx-1] + pair_len[idx-1] - 1;
                  else
                     pair_start[idx] = 64'(cfg_len) + 1;
               end
               2: pair_len[idx] = 64'(cfg_len) - pair_start[idx] + 1;
               default: begin
                  pair_start[idx] = rand64();
                  pair_len[idx]   = rand64();
               end
            endcase
         end
         default: ;
      endcase
      append_be(seq_field, 8);
      append_be(64'(win_field), 4);
      repeat (IV_BYTES_DEF) rec_bytes.insert(rec_bytes.size(), 8'($urandom));
      append_be(count_field, 8);
      foreach (pair_start[k]) begin
         append_be(pair_start[k], 8);
         append_be(pair_len[k], 8);
      end
      if (flavor == REC_COUNT_BAD && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 15)) rec_bytes.insert(rec_bytes.size(), 8'($urandom));
      if (flavor == REC_TRUNC) begin
         case ($urandom_range(0, 5))
            0: cut = HDR_END - 1;
            1: cut = HDR_END;
            2: cut = PREFIX_END - 1;
            3: cut = PREFIX_END + 7;
            default: cut = $urandom_range(1, rec_bytes.size() - 1);
         endcase
         if (cut >= rec_bytes.size())
            cut = rec_bytes.size() - 1;
         while (rec_bytes.size() > cut)
            rec_bytes.delete(rec_bytes.size() - 1);
      end
   endfunction

   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_send || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_byte(input logic [7:0] data, input logic last);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_record();
      foreach (rec_bytes[k])
         send_byte(rec_bytes[k], k == rec_bytes.size() - 1);
      sent_items += rec_bytes.size();
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(input logic [OUT_W-1:0] seq_len, input logic [WIN_W-1:0] window);
      csr_we    <= 1'b1;
      csr_index <= CSR_SEQ_LENGTH;
      csr_wdata <= seq_len;
      @(posedge clock);
      csr_index <= CSR_WINDOW_SIZE;
      csr_wdata <= (OUT_W'($urandom) << WIN_W) | OUT_W'(window);
      @(posedge clock);
      csr_we  <= 1'b0;
      cfg_len = seq_len;
      cfg_win = window;
   endtask

   // result side back-pressure
   initial begin
      int   r;
      int   run_left;
      logic run_ready;
      run_left  = 0;
      run_ready = 1'b0;
      wait (!reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            if (run_left == 0) begin
               r = $urandom_range(0, 99);
               run_ready = (r < 45 || (r >= 80 && r < 93));
               if (r < 45)
                  run_left = $urandom_range(1, 10);
               else if (r < 80)
                  run_left = $urandom_range(1, 3);
               else if (r < 93)
                  run_left = $urandom_range(20, 150);
               else
                  run_left = $urandom_range(8, 40);
            end
            rsp_tready <= run_ready;
            run_left--;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // short records at reset settings: lone byte, cut header, header only
      rec_bytes.delete();
      rec_bytes.insert(rec_bytes.size(), 8'hFF);
      send_record();
      rec_bytes.delete();
      repeat (HDR_END - 1) rec_bytes.insert(rec_bytes.size(), 8'h00);
      send_record();
      rec_bytes.delete();
      append_be(64'(cfg_len), SEQ_BYTES);
      append_be(64'(cfg_win), HDR_END - SEQ_BYTES);
      send_record();

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         case (phase)
            1: load_config('1, '1);
            2: load_config(OUT_W'(1), WIN_W'(1));
            3: load_config(OUT_W'($urandom_range(1, 5000)), WIN_W'($urandom_range(1, 65535)));
            4: load_config(OUT_W'(rand64()), WIN_W'($urandom_range(1, 65535)));
            5: load_config('0, WIN_W'($urandom_range(1, 300)));
            default: ;
         endcase
         if (phase == 1 || phase == 3) begin
            hold_rsp    = 1'b1;
            steady_send = 1'b1;
            build_record(REC_GOOD);
            send_record();
         end
         while (sent_items < DIRECTED_ITEMS + (phase + 1) * PHASE_ITEMS) begin
            steady_send = ($urandom_range(0, 3) == 0);
            build_record(pick_flavor());
            send_record();
            if ($urandom_range(0, 7) == 0)
               drain_results();
         end
      end
      drain_results();

      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
